/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL; compiled out when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that an expression holds at every clock edge out of reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed");
// Check that a condition in one cycle is followed by a result in the next.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define CHK_ALWAYS(label, clk, rst, expr)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/fspg_pkg.sv */
package fspg_pkg;

   localparam int MAX_SLOTS_DEFAULT   = 255;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_W         = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_GUEST_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUEST_SIZE = 2'd1;

   // Format characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_DOT     = 8'h2e;

   typedef enum logic [3:0] {
      PH_LIT   = 4'd0,
      PH_PCT   = 4'd1,
      PH_FLAGS = 4'd2,
      PH_WDIG  = 4'd3,
      PH_PREC  = 4'd4,
      PH_DOT   = 4'd5,
      PH_PDIG  = 4'd6,
      PH_LEN   = 4'd7,
      PH_TYPE  = 4'd8,
      PH_PEXT  = 4'd9,
      PH_STOP  = 4'd10,
      PH_ENDED = 4'd11
   } phase_type;

   typedef struct packed {
      logic [7:0]  fmt_char;
      logic        is_last;
      logic [63:0] next_slot_value;
   } req_type;

   typedef struct packed {
      logic       takes_slot;
      logic [7:0] slot_index;
      logic       clear_slot;
      logic       parse_stopped;
      logic       slot_overflow;
   } rsp_type;

   // Classified request, queued between front and back
   typedef struct packed {
      logic        take;
      logic        check;
      logic [7:0]  idx;
      logic        stopped;
      logic        ovf;
      logic [63:0] ptr;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      phase_type phase;
      logic      take;
      logic      check;
   } step_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alnum(logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_flag(logic [7:0] c);
      return (c == "-") || (c == "+") || (c == " ") || (c == "#") || (c == "0");
   endfunction

   function automatic logic is_len(logic [7:0] c);
      return (c == "h") || (c == "l") || (c == "L") || (c == "z") || (c == "t");
   endfunction

   function automatic logic is_plain_type(logic [7:0] c);
      return (c == "c") || (c == "d") || (c == "i") || (c == "o") || (c == "u") ||
             (c == "x") || (c == "y") || (c == "X");
   endfunction

   function automatic step_type mk_step(phase_type ph, logic take, logic check);
      step_type s;
      s.phase = ph;
      s.take  = take;
      s.check = check;
      return s;
   endfunction

   // Each helper gives the outcome of a character entering at that phase
   function automatic step_type from_lit(logic [7:0] c);
      return (c == CH_PERCENT) ? mk_step(PH_PCT, 1'b0, 1'b0) : mk_step(PH_LIT, 1'b0, 1'b0);
   endfunction

   function automatic step_type from_type(logic [7:0] c);
      step_type s;
      if ((c == "s") || (c == "n")) begin
         s = mk_step(PH_LIT, 1'b1, 1'b1);
      end else if (c == "p") begin
         s = mk_step(PH_PEXT, 1'b1, 1'b1);
      end else if (is_plain_type(c)) begin
         s = mk_step(PH_LIT, 1'b1, 1'b0);
      end else begin
         s = mk_step(PH_STOP, 1'b0, 1'b0);
      end
      return s;
   endfunction

   function automatic step_type from_len(logic [7:0] c);
      return is_len(c) ? mk_step(PH_LEN, 1'b0, 1'b0) : from_type(c);
   endfunction

   function automatic step_type from_prec(logic [7:0] c);
      return (c == CH_DOT) ? mk_step(PH_DOT, 1'b0, 1'b0) : from_len(c);
   endfunction

   function automatic step_type from_flags(logic [7:0] c);
      step_type s;
      if (is_flag(c)) begin
         s = mk_step(PH_FLAGS, 1'b0, 1'b0);
      end else if (c == CH_STAR) begin
         s = mk_step(PH_PREC, 1'b1, 1'b0);
      end else if (is_digit(c)) begin
         s = mk_step(PH_WDIG, 1'b0, 1'b0);
      end else begin
         s = from_prec(c);
      end
      return s;
   endfunction

   function automatic step_type from_dot(logic [7:0] c);
      step_type s;
      if (c == CH_STAR) begin
         s = mk_step(PH_LEN, 1'b1, 1'b0);
      end else if (is_digit(c)) begin
         s = mk_step(PH_PDIG, 1'b0, 1'b0);
      end else begin
         s = from_len(c);
      end
      return s;
   endfunction

   // Next phase and slot use for one format character
   function automatic step_type parse_step(phase_type ph, logic [7:0] c);
      step_type s;
      if ((c == CH_NUL) && (ph != PH_STOP)) begin
         s = mk_step(PH_ENDED, 1'b0, 1'b0);
      end else begin
         case (ph)
            PH_LIT: begin
               s = from_lit(c);
            end
            PH_PCT: begin
               s = (c == CH_PERCENT) ? mk_step(PH_LIT, 1'b0, 1'b0) : from_flags(c);
            end
            PH_FLAGS: begin
               s = from_flags(c);
            end
            PH_WDIG: begin
               s = is_digit(c) ? mk_step(PH_WDIG, 1'b0, 1'b0) : from_prec(c);
            end
            PH_PREC: begin
               s = from_prec(c);
            end
            PH_DOT: begin
               s = from_dot(c);
            end
            PH_PDIG: begin
               s = is_digit(c) ? mk_step(PH_PDIG, 1'b0, 1'b0) : from_len(c);
            end
            PH_LEN: begin
               s = from_len(c);
            end
            PH_TYPE: begin
               s = from_type(c);
            end
            PH_PEXT: begin
               s = is_alnum(c) ? mk_step(PH_PEXT, 1'b0, 1'b0) : from_lit(c);
            end
            PH_STOP: begin
               s = mk_step(PH_STOP, 1'b0, 1'b0);
            end
            PH_ENDED: begin
               s = mk_step(PH_ENDED, 1'b0, 1'b0);
            end
            default: begin
               s = from_lit(c);
            end
         endcase
      end
      return s;
   endfunction

endpackage

/* sv/fspg_front.sv */
`include "assert_macros.svh"

module fspg_front
   import fspg_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output job_type push_data
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   step_type         step;
   logic             sat;
   logic [CNT_W+7:0] idx_wide;

   // Classify the character against the current phase
   always_comb begin
      push     = req_valid && !req_stall;
      step     = parse_step(phase_ff, req_data.fmt_char);
      sat      = count_ff >= CNT_MAX;
      idx_wide = {8'b0, count_ff};

      push_data.take    = step.take;
      push_data.check   = step.take && step.check;
      push_data.idx     = step.take ? idx_wide[7:0] : 8'b0;
      push_data.stopped = step.phase == PH_STOP;
      push_data.ovf     = step.take && sat;
      push_data.ptr     = req_data.next_slot_value;
   end

   // Advance phase and slot count; the end mark starts a new string
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (push) begin
         if (req_data.is_last) begin
            phase_in = PH_LIT;
            count_in = '0;
         end else begin
            phase_in = step.phase;
            if (step.take && !sat) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LIT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   `CHK_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_MAX)
   `CHK_NEXT(a_last_clears, clock, reset, push && req_data.is_last, (phase_ff == PH_LIT) && (count_ff == '0))

endmodule

/* sv/fspg_queue.sv */
`include "assert_macros.svh"

module fspg_queue
   import fspg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.full      = count_ff == CNT_FULL;
      status.not_empty = count_ff != '0;
      pop_data         = entry_ff[rd_ptr_ff];
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CHK_ALWAYS(a_no_overrun, clock, reset, !(push && status.full && !pop) && !(pop && !status.not_empty))
   `CHK_NEXT(a_drain_count, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

/* sv/fspg_back.sv */
`include "assert_macros.svh"

module fspg_back
   import fspg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata,
   input  job_type                pop_data,
   input  queue_status_type       q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   logic [63:0] guest_base_ff;
   logic [63:0] guest_size_ff;
   logic [63:0] offset;
   logic        clear;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Write the guest window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         guest_base_ff <= '0;
         guest_size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GUEST_BASE: guest_base_ff <= csr_wdata;
            CSR_GUEST_SIZE: guest_size_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Check the pointer against the guest window and load the output register
   always_comb begin
      pop    = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
      offset = pop_data.ptr - guest_base_ff;
      clear  = pop_data.check && (pop_data.ptr != '0) && (offset >= guest_size_ff);

      rsp_data_in.takes_slot    = pop_data.take;
      rsp_data_in.slot_index    = pop_data.idx;
      rsp_data_in.clear_slot    = clear;
      rsp_data_in.parse_stopped = pop_data.stopped;
      rsp_data_in.slot_overflow = pop_data.ovf;

      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHK_ALWAYS(a_idle_fields, clock, reset, !rsp_valid_ff || rsp_data_ff.takes_slot || (!rsp_data_ff.clear_slot && !rsp_data_ff.slot_overflow && (rsp_data_ff.slot_index == 8'd0)))

endmodule

/* sv/format_string_pointer_guard_core.sv */
// Format string pointer guard.
// Each request carries one format character, an end-of-string mark and the
// contents of the next unconsumed argument slot. Each request yields exactly
// one response: whether the character takes a slot, the slot number, whether
// a non-null %s, %p or %n pointer falls outside the guest window, a
// halted-parse flag and a slot counter overflow flag. The front classifies
// one accepted character per cycle against the conversion phase; a queue of
// QUEUE_DEPTH entries feeds the back, which does the 64-bit window compare
// and holds the response in an output register. A request passes through
// the queue into that register. Throughput: one request per cycle while
// req_stall is low, set by the phase update in the front. The guest window
// is set through the csr_ port, always ready; the user must do so only while
// no request is in flight, as the block does not enforce it. Reset clears
// the phase, slot counter, queue pointers and count, response valid flag
// and window registers. When rsp_stall holds, the response stays and the
// queue fills; req_stall rises once the queue is full.
module format_string_pointer_guard_core
   import fspg_pkg::*;
#(
   parameter int MAX_SLOTS   = MAX_SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata
);

   logic             push;
   logic             pop;
   job_type          push_data;
   job_type          pop_data;
   queue_status_type q_status;

   // Stall requests only when the queue has no room
   assign req_stall = q_status.full;
   assign csr_ready = 1'b1;

   fspg_front #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .push     (push),
      .push_data(push_data)
   );

   fspg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .status   (q_status)
   );

   fspg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pop_data (pop_data),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
